### hdl/rk2_pkg.sv
// ----------------------------------------------------------------------------
// rk2_pkg: shared types and constants of the rank-2 update block
// Holds the configuration bundle, the side data that travels with an item
// through the arithmetic pipeline, and the saturation limits.
// ----------------------------------------------------------------------------
package rk2_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 2 * SAMPLE_W;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic                       hermitian;
    logic signed [SAMPLE_W-1:0] alpha_re;
    logic signed [SAMPLE_W-1:0] alpha_im;
  } rk2_cfg_t;

  typedef struct packed {
    logic                       err;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } rk2_side_t;

endpackage

### hdl/symmetric_rank2_update.sv
// ----------------------------------------------------------------------------
// symmetric_rank2_update: complex symmetric / Hermitian rank-2 element update
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         s_axis_tvalid/tready      load x, load y or update item
//   m_axis    out        m_axis_tvalid/tready      updated element and flags
//   apb       in         psel/penable/pwrite       order, mode, alpha
//
// One item is accepted per cycle while s_axis_tready is high. For an update
// item the vector memories are read at the accepting edge, then
// six arithmetic stages follow, the last being the output register. Loads
// write the x or y memory at acceptance and give no result. A low
// m_axis_tready lets the seven stages fill, then s_axis_tready drops. Reset
// clears the valid bits and the configuration registers; the vector memories and data registers are not reset.
// ----------------------------------------------------------------------------
module symmetric_rank2_update #(
  parameter int MAX_ORDER = 64,
  parameter int FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: row_index[5:0], col_index[11:6], value_real[27:12],
  // value_imag[43:28], zero padding[47:44]
  input  logic [47:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_real[15:0], result_imag[31:16]
  output logic [31:0] m_axis_tdata,
  // tuser: index_error[0], saturated[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_ORDER);
  localparam int EW = (AW > 6) ? AW : 6;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_SIZE     = 2'd0,
    REG_HERM     = 2'd1,
    REG_ALPHA_RE = 2'd2,
    REG_ALPHA_IM = 2'd3
  } reg_e;

  logic [6:0]  size_q;
  logic        herm_q;
  logic [15:0] alpha_re_q;
  logic [15:0] alpha_im_q;
  logic        cfg_we;
  reg_e        reg_idx;

  op_e         op;
  logic [5:0]  row, col;
  logic [15:0] val_re, val_im;
  logic        fire, en1, row_lt_max, col_lt_max, i_ok, j_ok;
  logic [EW-1:0] row_ext, col_ext;
  logic [AW-1:0] addr_i, addr_j;
  logic        we_x, we_y;

  logic [rk2_pkg::WORD_W-1:0] xi, xj, yi, yj;
  logic               v1_q;
  rk2_pkg::rk2_side_t side1_q;
  rk2_pkg::rk2_side_t side1_d;
  rk2_pkg::rk2_cfg_t  cfg;
  logic               arith_ready;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= 7'd64;
      herm_q     <= 1'b0;
      alpha_re_q <= 16'h7fff;
      alpha_im_q <= 16'h0000;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SIZE:     size_q     <= pwdata[6:0];
        REG_HERM:     herm_q     <= pwdata[0];
        REG_ALPHA_RE: alpha_re_q <= pwdata[15:0];
        REG_ALPHA_IM: alpha_im_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE:     prdata = {25'b0, size_q};
      REG_HERM:     prdata = {31'b0, herm_q};
      REG_ALPHA_RE: prdata = {16'b0, alpha_re_q};
      REG_ALPHA_IM: prdata = {16'b0, alpha_im_q};
      default:      prdata = 32'b0;
    endcase
  end

  assign cfg.hermitian = herm_q;
  assign cfg.alpha_re  = alpha_re_q;
  assign cfg.alpha_im  = alpha_im_q;

  // Input decode and index checks.
  assign op     = op_e'(s_axis_tuser);
  assign row    = s_axis_tdata[5:0];
  assign col    = s_axis_tdata[11:6];
  assign val_re = s_axis_tdata[27:12];
  assign val_im = s_axis_tdata[43:28];

  assign row_lt_max = 32'(row) < 32'(MAX_ORDER);
  assign col_lt_max = 32'(col) < 32'(MAX_ORDER);
  assign i_ok       = ({1'b0, row} < size_q) && row_lt_max;
  assign j_ok       = ({1'b0, col} < size_q) && col_lt_max;

  assign row_ext = EW'(row);
  assign col_ext = EW'(col);
  assign addr_i  = row_ext[AW-1:0];
  assign addr_j  = col_ext[AW-1:0];

  assign en1           = !v1_q || arith_ready;
  assign s_axis_tready = en1;
  assign fire          = s_axis_tvalid && en1;
  assign we_x          = fire && (op == OP_LOAD_X) && row_lt_max;
  assign we_y          = fire && (op == OP_LOAD_Y) && row_lt_max;

  assign side1_d.err = !(i_ok && j_ok && (col <= row));
  assign side1_d.re  = val_re;
  assign side1_d.im  = val_im;

  rk2_vec_store #(
    .DEPTH(MAX_ORDER),
    .AW   (AW)
  ) u_x_store (
    .clk_i    (clk_i),
    .we_i     (we_x),
    .waddr_i  (addr_i),
    .wdata_i  (s_axis_tdata[43:12]),
    .re_i     (en1),
    .raddr_a_i(addr_i),
    .raddr_b_i(addr_j),
    .rdata_a_o(xi),
    .rdata_b_o(xj)
  );

  rk2_vec_store #(
    .DEPTH(MAX_ORDER),
    .AW   (AW)
  ) u_y_store (
    .clk_i    (clk_i),
    .we_i     (we_y),
    .waddr_i  (addr_i),
    .wdata_i  (s_axis_tdata[43:12]),
    .re_i     (en1),
    .raddr_a_i(addr_i),
    .raddr_b_i(addr_j),
    .rdata_a_o(yi),
    .rdata_b_o(yj)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= fire && (op == OP_UPDATE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      side1_q <= side1_d;
    end
  end

  rk2_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (v1_q),
    .in_ready_o   (arith_ready),
    .xi_i         (xi),
    .xj_i         (xj),
    .yi_i         (yi),
    .yj_i         (yj),
    .side_i       (side1_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_re_o  (m_axis_tdata[15:0]),
    .result_im_o  (m_axis_tdata[31:16]),
    .index_error_o(m_axis_tuser[0]),
    .saturated_o  (m_axis_tuser[1])
  );

endmodule

### hdl/rk2_vec_store.sv
// ----------------------------------------------------------------------------
// rk2_vec_store: vector element memory
// One write port and two registered read ports. Read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module rk2_vec_store #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [rk2_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [rk2_pkg::WORD_W-1:0] rdata_a_o,
  output logic [rk2_pkg::WORD_W-1:0] rdata_b_o
);

  logic [rk2_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [rk2_pkg::WORD_W-1:0] rdata_a_q;
  logic [rk2_pkg::WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hdl/rk2_arith.sv
// ----------------------------------------------------------------------------
// rk2_arith: complex rank-2 arithmetic pipeline
// Six register stages: element products, complex sums, products with alpha,
// update term, rounding, and the addition of A with saturation into the
// output register. Each stage moves when it is empty or the next one moves.
// ----------------------------------------------------------------------------
module rk2_arith #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rk2_pkg::rk2_cfg_t            cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rk2_pkg::WORD_W-1:0]   xi_i,
  input  logic [rk2_pkg::WORD_W-1:0]   xj_i,
  input  logic [rk2_pkg::WORD_W-1:0]   yi_i,
  input  logic [rk2_pkg::WORD_W-1:0]   yj_i,
  input  rk2_pkg::rk2_side_t           side_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rk2_pkg::SAMPLE_W-1:0] result_re_o,
  output logic [rk2_pkg::SAMPLE_W-1:0] result_im_o,
  output logic                         index_error_o,
  output logic                         saturated_o
);

  localparam int OW    = rk2_pkg::SAMPLE_W + 1;
  localparam int PW    = 2 * OW;
  localparam int UW    = PW + 1;
  localparam int QW    = OW + UW;
  localparam int TW    = QW + 2;
  localparam int SHIFT = 2 * FRAC_BITS;
  localparam int SW    = ((TW > SHIFT + 1) ? TW : SHIFT + 1) + 1;
  localparam int RW    = SW - SHIFT;
  localparam int FW    = ((RW > rk2_pkg::SAMPLE_W) ? RW : rk2_pkg::SAMPLE_W) + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (SHIFT - 1);

  logic en2, en3, en4, en5, en6, en7;
  logic v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  rk2_pkg::rk2_side_t side2_q, side3_q, side4_q, side5_q, side6_q;

  logic signed [OW-1:0] xir, xii, yir, yii, xjr, xji, yjr, yji, xjc, yjc;
  logic signed [PW-1:0] pa_d [4];
  logic signed [PW-1:0] pb_d [4];
  logic signed [PW-1:0] pa_q [4];
  logic signed [PW-1:0] pb_q [4];

  logic signed [UW-1:0] ur_d, ui_d, wr_d, wi_d;
  logic signed [UW-1:0] ur_q, ui_q, wr_q, wi_q;

  logic signed [OW-1:0] ar, ai, bi;
  logic signed [QW-1:0] q_d [8];
  logic signed [QW-1:0] q_q [8];

  logic signed [TW-1:0] tr_d, ti_d, tr_q, ti_q;

  logic signed [SW-1:0] tr_ext, ti_ext, tr_sh, ti_sh;
  logic signed [RW-1:0] rr_d, ri_d, rr_q, ri_q;

  logic signed [FW-1:0] sum_re, sum_im;
  logic                 clip_re, clip_im;
  logic signed [rk2_pkg::SAMPLE_W-1:0] sat_re, sat_im;

  logic                               out_valid_q;
  logic [rk2_pkg::SAMPLE_W-1:0]       res_re_q, res_im_q;
  logic                               err_q, sat_q;

  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign in_ready_o = en2;
  assign v7_q = out_valid_q;

  // Element products; the Hermitian update conjugates the column elements.
  always_comb begin
    xir = {xi_i[15], xi_i[15:0]};
    xii = {xi_i[31], xi_i[31:16]};
    yir = {yi_i[15], yi_i[15:0]};
    yii = {yi_i[31], yi_i[31:16]};
    xjr = {xj_i[15], xj_i[15:0]};
    xji = {xj_i[31], xj_i[31:16]};
    yjr = {yj_i[15], yj_i[15:0]};
    yji = {yj_i[31], yj_i[31:16]};
    xjc = cfg_i.hermitian ? -xji : xji;
    yjc = cfg_i.hermitian ? -yji : yji;
    pa_d[0] = xir * yjr;
    pa_d[1] = xii * yjc;
    pa_d[2] = xir * yjc;
    pa_d[3] = xii * yjr;
    pb_d[0] = yir * xjr;
    pb_d[1] = yii * xjc;
    pb_d[2] = yir * xjc;
    pb_d[3] = yii * xjr;
  end

  always_comb begin
    ur_d = UW'(pa_q[0]) - UW'(pa_q[1]);
    ui_d = UW'(pa_q[2]) + UW'(pa_q[3]);
    wr_d = UW'(pb_q[0]) - UW'(pb_q[1]);
    wi_d = UW'(pb_q[2]) + UW'(pb_q[3]);
  end

  // The second term takes conj(alpha) in the Hermitian update.
  always_comb begin
    ar = {cfg_i.alpha_re[15], cfg_i.alpha_re};
    ai = {cfg_i.alpha_im[15], cfg_i.alpha_im};
    bi = cfg_i.hermitian ? -ai : ai;
    q_d[0] = ar * ur_q;
    q_d[1] = ai * ui_q;
    q_d[2] = ar * ui_q;
    q_d[3] = ai * ur_q;
    q_d[4] = ar * wr_q;
    q_d[5] = bi * wi_q;
    q_d[6] = ar * wi_q;
    q_d[7] = bi * wr_q;
  end

  always_comb begin
    tr_d = TW'(q_q[0]) - TW'(q_q[1]) + TW'(q_q[4]) - TW'(q_q[5]);
    ti_d = TW'(q_q[2]) + TW'(q_q[3]) + TW'(q_q[6]) + TW'(q_q[7]);
  end

  // Round half up: add half an output step, then take the floor.
  always_comb begin
    tr_ext = SW'(tr_q) + HALF;
    ti_ext = SW'(ti_q) + HALF;
    tr_sh  = tr_ext >>> SHIFT;
    ti_sh  = ti_ext >>> SHIFT;
    rr_d   = tr_sh[RW-1:0];
    ri_d   = ti_sh[RW-1:0];
  end

  always_comb begin
    sum_re  = FW'(rr_q) + FW'(side6_q.re);
    sum_im  = FW'(ri_q) + FW'(side6_q.im);
    clip_re = !((&sum_re[FW-1:rk2_pkg::SAMPLE_W-1]) || !(|sum_re[FW-1:rk2_pkg::SAMPLE_W-1]));
    clip_im = !((&sum_im[FW-1:rk2_pkg::SAMPLE_W-1]) || !(|sum_im[FW-1:rk2_pkg::SAMPLE_W-1]));
    if (clip_re) begin
      sat_re = sum_re[FW-1] ? rk2_pkg::SAT_MIN : rk2_pkg::SAT_MAX;
    end else begin
      sat_re = sum_re[rk2_pkg::SAMPLE_W-1:0];
    end
    if (clip_im) begin
      sat_im = sum_im[FW-1] ? rk2_pkg::SAT_MIN : rk2_pkg::SAT_MAX;
    end else begin
      sat_im = sum_im[rk2_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) v2_q <= in_valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      side2_q <= side_i;
    end
    if (en3) begin
      ur_q    <= ur_d;
      ui_q    <= ui_d;
      wr_q    <= wr_d;
      wi_q    <= wi_d;
      side3_q <= side2_q;
    end
    if (en4) begin
      q_q     <= q_d;
      side4_q <= side3_q;
    end
    if (en5) begin
      tr_q    <= tr_d;
      ti_q    <= ti_d;
      side5_q <= side4_q;
    end
    if (en6) begin
      rr_q    <= rr_d;
      ri_q    <= ri_d;
      side6_q <= side5_q;
    end
    if (en7) begin
      if (side6_q.err) begin
        res_re_q <= side6_q.re;
        res_im_q <= side6_q.im;
        err_q    <= 1'b1;
        sat_q    <= 1'b0;
      end else begin
        res_re_q <= sat_re;
        res_im_q <= sat_im;
        err_q    <= 1'b0;
        sat_q    <= clip_re || clip_im;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_re_o   = res_re_q;
  assign result_im_o   = res_im_q;
  assign index_error_o = err_q;
  assign saturated_o   = sat_q;

endmodule

### hdl/rk2_checker.sv
// ----------------------------------------------------------------------------
// rk2_checker: port-level checks for symmetric_rank2_update
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module rk2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // An item with an index error returns A unchanged and is never clipped.
  a_err_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("index error item flagged as saturated");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  // Input is refused only when every stage is full behind a stalled output.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without a stalled output");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind symmetric_rank2_update rk2_checker u_rk2_checker (.*);

### test/rank2_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank2_update_checker: scoreboard for the rank-2 matrix element update
// Watches the input stream, the output stream and the register port. It keeps
// its own copy of the vector stores and the registers and works out the
// updated element for every accepted update item. It then compares each
// returned item field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package rank2_tb_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_UPDATE = 2'd2,
    OP_UNUSED = 2'd3
  } rank2_op_e;

  localparam logic [3:0] ADDR_ORDER     = 4'h0;
  localparam logic [3:0] ADDR_HERMITIAN = 4'h4;
  localparam logic [3:0] ADDR_ALPHA_RE  = 4'h8;
  localparam logic [3:0] ADDR_ALPHA_IM  = 4'hc;

  localparam int ORDER_MAX = 64;

endpackage

module rank2_update_checker
  import rk2_pkg::*;
  import rank2_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       err;
    logic                       sat;
  } elem_result_t;

  logic [WORD_W-1:0] x_mem [ORDER_MAX];
  logic [WORD_W-1:0] y_mem [ORDER_MAX];
  logic [6:0]        order;
  rk2_cfg_t          cfg;
  elem_result_t      updated_q [$];
  int                mismatches;

  assign fail_count_o = mismatches;

  function automatic longint part(input logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [15:0] clip16(input longint v, inout logic hit);
    if (v > longint'(SAT_MAX)) begin
      hit = 1'b1;
      return SAT_MAX;
    end
    if (v < longint'(SAT_MIN)) begin
      hit = 1'b1;
      return SAT_MIN;
    end
    return v[15:0];
  endfunction

  function automatic elem_result_t update_element(input logic [5:0] row, col,
                                                  input logic [15:0] a_re, a_im);
    elem_result_t r;
    int           n;
    longint       xir, xii, yir, yii, xjr, xji, yjr, yji, ar, ai;
    longint       ur, ui, wr, wi, sr, si, tr, ti;
    logic         hit;
    n     = (order > ORDER_MAX) ? ORDER_MAX : int'(order);
    r.re  = a_re;
    r.im  = a_im;
    r.err = 1'b0;
    r.sat = 1'b0;
    if (int'(row) >= n || int'(col) >= n || col > row) begin
      r.err = 1'b1;
      return r;
    end
    ar  = longint'(cfg.alpha_re);
    ai  = longint'(cfg.alpha_im);
    xir = part(x_mem[row][15:0]);
    xii = part(x_mem[row][31:16]);
    yir = part(y_mem[row][15:0]);
    yii = part(y_mem[row][31:16]);
    xjr = part(x_mem[col][15:0]);
    xji = part(x_mem[col][31:16]);
    yjr = part(y_mem[col][15:0]);
    yji = part(y_mem[col][31:16]);
    if (cfg.hermitian) begin
      ur = xir * yjr + xii * yji;
      ui = xii * yjr - xir * yji;
      wr = yir * xjr + yii * xji;
      wi = yii * xjr - yir * xji;
      tr = ar * ur - ai * ui + ar * wr + ai * wi;
      ti = ar * ui + ai * ur + ar * wi - ai * wr;
    end else begin
      sr = xir * yjr - xii * yji + yir * xjr - yii * xji;
      si = xir * yji + xii * yjr + yir * xji + yii * xjr;
      tr = ar * sr - ai * si;
      ti = ar * si + ai * sr;
    end
    hit  = 1'b0;
    r.re = clip16(part(a_re) + ((tr + (longint'(1) <<< 29)) >>> 30), hit);
    r.im = clip16(part(a_im) + ((ti + (longint'(1) <<< 29)) >>> 30), hit);
    r.sat = hit;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    elem_result_t exp_r;
    if (!rst_ni) begin
      order = 7'd64;
      cfg   = '{hermitian: 1'b0, alpha_re: 16'sd32767, alpha_im: 16'sd0};
      updated_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_ORDER:     order        = pwdata[6:0];
          ADDR_HERMITIAN: cfg.hermitian = pwdata[0];
          ADDR_ALPHA_RE:  cfg.alpha_re  = pwdata[15:0];
          ADDR_ALPHA_IM:  cfg.alpha_im  = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (rank2_op_e'(s_axis_tuser))
          OP_LOAD_X: x_mem[s_axis_tdata[5:0]] = s_axis_tdata[43:12];
          OP_LOAD_Y: y_mem[s_axis_tdata[5:0]] = s_axis_tdata[43:12];
          OP_UPDATE: updated_q.push_back(update_element(s_axis_tdata[5:0],
                                                        s_axis_tdata[11:6],
                                                        s_axis_tdata[27:12],
                                                        s_axis_tdata[43:28]));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (updated_q.size() == 0) begin
          report("result item with no prediction outstanding");
        end else begin
          exp_r = updated_q.pop_front();
          if (m_axis_tdata[15:0] !== exp_r.re)
            report($sformatf("result_real got %h expected %h", m_axis_tdata[15:0], exp_r.re));
          if (m_axis_tdata[31:16] !== exp_r.im)
            report($sformatf("result_imag got %h expected %h", m_axis_tdata[31:16], exp_r.im));
          if (m_axis_tuser[0] !== exp_r.err)
            report($sformatf("index_error got %b expected %b", m_axis_tuser[0], exp_r.err));
          if (m_axis_tuser[1] !== exp_r.sat)
            report($sformatf("saturated got %b expected %b", m_axis_tuser[1], exp_r.sat));
        end
      end
      pending_o <= updated_q.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for symmetric_rank2_update
// Loads the vector stores, streams directed and random update items under a
// series of register settings, and lets the receiver stall at random with
// long hold-offs. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import rank2_tb_pkg::*;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 12;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_UNUSED;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int          burst_left = 0;
  int          cur_order  = 64;
  bit          x_loaded [ORDER_MAX];
  bit          y_loaded [ORDER_MAX];

  symmetric_rank2_update i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rank2_update_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input rank2_op_e op, input logic [5:0] row, col,
                           input logic [15:0] re, im);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, im, re, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic send_load(input rank2_op_e op, input logic [5:0] idx,
                           input logic [15:0] re, im);
    if (op == OP_LOAD_X) x_loaded[idx] = 1'b1;
    else y_loaded[idx] = 1'b1;
    send_item(op, idx, 6'($urandom), re, im);
  endtask

  // Vector entries that the update may read are loaded first.
  task automatic send_update(input logic [5:0] row, col, input logic [15:0] re, im);
    if (!x_loaded[row]) send_load(OP_LOAD_X, row, pick_sample(), pick_sample());
    if (!y_loaded[row]) send_load(OP_LOAD_Y, row, pick_sample(), pick_sample());
    if (!x_loaded[col]) send_load(OP_LOAD_X, col, pick_sample(), pick_sample());
    if (!y_loaded[col]) send_load(OP_LOAD_Y, col, pick_sample(), pick_sample());
    send_item(OP_UPDATE, row, col, re, im);
  endtask

  task automatic random_item();
    int          pick;
    logic [5:0]  row, col;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      row = (cur_order > 0 && $urandom_range(0, 3) != 0) ?
            6'($urandom_range(0, cur_order - 1)) : 6'($urandom_range(0, ORDER_MAX - 1));
      send_load((pick < 12) ? OP_LOAD_X : OP_LOAD_Y, row, pick_sample(), pick_sample());
    end else if (pick < 27) begin
      send_item(OP_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      if (cur_order > 0 && $urandom_range(0, 4) != 0) begin
        row = 6'($urandom_range(0, cur_order - 1));
        col = 6'($urandom_range(0, row));
      end else begin
        row = 6'($urandom);
        col = 6'($urandom);
      end
      send_update(row, col, pick_sample(), pick_sample());
    end
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [6:0] order, input logic herm,
                            input logic [15:0] a_re, a_im);
    write_reg(ADDR_ORDER, {25'd0, order});
    write_reg(ADDR_HERMITIAN, {31'd0, herm});
    write_reg(ADDR_ALPHA_RE, {16'd0, a_re});
    write_reg(ADDR_ALPHA_IM, {16'd0, a_im});
    cur_order = (order > ORDER_MAX) ? ORDER_MAX : int'(order);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : receiver
    int mode, span, seg;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg % 5 == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(250, 400)) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
        repeat (span) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_load(OP_LOAD_X, 6'd0, 16'h7fff, 16'h8000);
    send_load(OP_LOAD_Y, 6'd0, 16'h8000, 16'h7fff);
    send_load(OP_LOAD_X, 6'd63, 16'h8000, 16'h8000);
    send_load(OP_LOAD_Y, 6'd63, 16'h8000, 16'h8000);
    send_update(6'd0, 6'd0, 16'h7fff, 16'h7fff);
    send_update(6'd63, 6'd63, 16'h8000, 16'h8000);
    send_update(6'd63, 6'd0, 16'h0000, 16'h0000);
    send_update(6'd0, 6'd63, 16'h1234, 16'hffff);
    send_item(OP_UNUSED, 6'd63, 6'd63, 16'hffff, 16'hffff);
    send_load(OP_LOAD_X, 6'd63, 16'h0000, 16'h0000);
    send_load(OP_LOAD_Y, 6'd63, 16'hffff, 16'h0001);
    send_update(6'd63, 6'd0, 16'h7fff, 16'h8000);
    send_update(6'd63, 6'd63, 16'h0001, 16'hffff);
    send_update(6'd62, 6'd63, 16'h5555, 16'haaaa);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(7'd64, 1'b1, 16'h8000, 16'h8000);
        1: set_config(7'd1, 1'b0, 16'h7fff, 16'h7fff);
        2: set_config(7'd8, 1'b1, 16'($urandom), 16'($urandom));
        3: set_config(7'd0, 1'b0, 16'd12345, 16'ha460);
        4: set_config(7'd100, 1'b1, 16'($urandom), 16'($urandom));
        5: set_config(7'd64, 1'b0, 16'h8000, 16'h7fff);
        6: set_config(7'd33, 1'b1, 16'($urandom), 16'($urandom));
        default: set_config(7'($urandom_range(2, 64)), 1'b0, 16'($urandom),
                            16'($urandom));
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
